[sv/tvh_pkg.sv]
// ----------------------------------------------------------------------------
// tvh_pkg: shared types and constants
// Action codes, register indexes and the divider control types.
// ----------------------------------------------------------------------------
package tvh_pkg;

    // input item actions
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_LOAD   = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_TWO_DIM = 2'd0;
    localparam logic [1:0] REG_BINS    = 2'd1;
    localparam logic [1:0] REG_RANGE   = 2'd2;
    localparam logic [1:0] REG_TCOUNT  = 2'd3;

    // divider operand widths
    localparam int DIV_W = 65;
    localparam int DSR_W = 33;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

[sv/tvh_ram.sv]
// ----------------------------------------------------------------------------
// tvh_ram: generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tvh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/tvh_div.sv]
// ----------------------------------------------------------------------------
// tvh_div: restoring divider
// Unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tvh_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tvh_pkg::div_ctl_t           ctl,
    input  logic [tvh_pkg::DIV_W-1:0]   dividend,
    input  logic [tvh_pkg::DSR_W-1:0]   divisor,
    output tvh_pkg::div_sts_t           sts,
    output logic [tvh_pkg::DIV_W-1:0]   quotient
);

    localparam int CW = $clog2(tvh_pkg::DIV_W + 1);

    logic [tvh_pkg::DSR_W-1:0] rem_reg;
    logic [tvh_pkg::DSR_W-1:0] dsr_reg;
    logic [tvh_pkg::DIV_W-1:0] quo_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [tvh_pkg::DSR_W:0]   rem_sh;
    logic [tvh_pkg::DSR_W+1:0] trial;
    logic                      ge;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        rem_sh = {rem_reg, quo_reg[tvh_pkg::DIV_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, dsr_reg};
        ge     = ~trial[tvh_pkg::DSR_W+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(tvh_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: load operands, then one bit per cycle
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? trial[tvh_pkg::DSR_W-1:0] : rem_sh[tvh_pkg::DSR_W-1:0];
            quo_reg <= {quo_reg[tvh_pkg::DIV_W-2:0], ge};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/timed_velocity_histogram.sv]
// ----------------------------------------------------------------------------
// timed_velocity_histogram: interpolated velocity histograms
// Follows one trajectory, interpolates velocity at each observation time a
// sample passes and counts it in that time's 1-D or 2-D histogram.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  action, time, velocities, slot, bins
//  m_       out        m_valid / m_ready  keep_tracing, recorded_count, bin_value
//  cfg_     in         cfg_we             cfg_index, cfg_data
//
//  A sample bins each axis per passed observation time, interpolating it
//  first when the time has risen: each interpolation and each unclamped
//  binning holds a pass of the shared restoring divider, with the shared
//  multiplier ahead; a value that clamps skips the divider.
//  After reset a clearing pass zeroes all MAX_TIMES*MAX_BINS*MAX_BINS words
//  of the histogram RAM; s_ready stays low meanwhile, cfg writes are taken.
//  One item is in work at a time; a waiting result holds the next finish.
// ----------------------------------------------------------------------------
module timed_velocity_histogram #(
    parameter int MAX_TIMES = 16,
    parameter int MAX_BINS  = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [31:0]        s_time_value,
    input  logic signed [31:0] s_vel_first,
    input  logic signed [31:0] s_vel_second,
    input  logic [3:0]         s_slot_index,
    input  logic [4:0]         s_read_bin_first,
    input  logic [4:0]         s_read_bin_second,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_keep_tracing,
    output logic [4:0]         m_recorded_count,
    output logic [31:0]        m_bin_value
);

    localparam int TIW       = (MAX_TIMES > 1) ? $clog2(MAX_TIMES) : 1;
    localparam int NSW       = $clog2(MAX_TIMES + 1);
    localparam int BIW       = $clog2(MAX_BINS);
    localparam int BCW       = $clog2(MAX_BINS + 1);
    localparam int HIST_SIZE = MAX_TIMES * MAX_BINS * MAX_BINS;
    localparam int HAW       = $clog2(HIST_SIZE);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_EXEC      = 4'd1;
    localparam logic [3:0] ST_CHECK     = 4'd2;
    localparam logic [3:0] ST_MUL       = 4'd3;
    localparam logic [3:0] ST_DIV_GO    = 4'd4;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd5;
    localparam logic [3:0] ST_BIN       = 4'd6;
    localparam logic [3:0] ST_BDIV_GO   = 4'd7;
    localparam logic [3:0] ST_BDIV_WAIT = 4'd8;
    localparam logic [3:0] ST_RMW_RD    = 4'd9;
    localparam logic [3:0] ST_RMW_WR    = 4'd10;
    localparam logic [3:0] ST_END       = 4'd11;
    localparam logic [3:0] ST_RD        = 4'd12;
    localparam logic [3:0] ST_RD_DATA   = 4'd13;
    localparam logic [3:0] ST_FINISH    = 4'd14;

    // configuration
    logic        two_dim_reg;
    logic [5:0]  bins_reg;
    logic [31:0] range_reg;
    logic [4:0]  tcount_reg;

    // latched item
    logic [1:0]         act_reg;
    logic [31:0]        t_reg;
    logic signed [31:0] v1_reg;
    logic signed [31:0] v2_reg;
    logic [3:0]         slot_reg;
    logic [4:0]         rb1_reg;
    logic [4:0]         rb2_reg;

    // trajectory state
    logic [31:0]        obs_mem [MAX_TIMES];
    logic [NSW-1:0]     next_slot_reg, next_slot_next;
    logic [31:0]        prev_t_reg;
    logic signed [31:0] pv1_reg;
    logic signed [31:0] pv2_reg;

    // working registers
    logic [3:0]         state_reg, state_next;
    logic               comp_reg;
    logic [31:0]        num_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;
    logic [64:0]        prod_reg;
    logic signed [33:0] iv1_reg;
    logic signed [33:0] iv2_reg;
    logic [BIW-1:0]     idx1_reg;
    logic [BIW-1:0]     idx2_reg;
    logic [NSW-1:0]     rec_reg;
    logic               rd_ok_reg;
    logic               res_keep_reg;
    logic [31:0]        res_val_reg;

    // result channel
    logic        m_valid_reg;
    logic        m_keep_reg;
    logic [4:0]  m_rec_reg;
    logic [31:0] m_val_reg;

    // clearing pass
    logic           clr_busy_reg;
    logic [HAW-1:0] clr_addr_reg;

    // derived configuration
    logic [NSW-1:0]     count_w;
    logic [BCW-1:0]     bins_eff;
    logic [BIW-1:0]     bins_m1;
    logic [31:0]        range_eff;
    logic signed [33:0] range_s;

    // sample datapath
    logic [31:0]        obs_cur;
    logic signed [31:0] old_sel;
    logic signed [31:0] cur_sel;
    logic signed [33:0] diff;
    logic [32:0]        mag;
    logic signed [33:0] q34;
    logic signed [33:0] old34;
    logic signed [33:0] interp_res;
    logic signed [33:0] bv;
    logic signed [33:0] bs;
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        mul_p;

    // RAM and divider
    logic [HAW-1:0]     rmw_addr;
    logic [HAW-1:0]     rd_addr;
    logic [4:0]         rb2_eff;
    logic               ram_we;
    logic [HAW-1:0]     ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [HAW-1:0]     ram_raddr;
    logic [31:0]        ram_rdata;
    tvh_pkg::div_ctl_t  div_ctl;
    tvh_pkg::div_sts_t  div_sts;
    logic [tvh_pkg::DIV_W-1:0] div_dividend;
    logic [tvh_pkg::DSR_W-1:0] div_divisor;
    logic [tvh_pkg::DIV_W-1:0] div_quo;

    // clamp the configuration into usable values
    always_comb begin
        if (int'(tcount_reg) < MAX_TIMES) begin
            count_w = NSW'(tcount_reg);
        end else begin
            count_w = NSW'(MAX_TIMES);
        end
        if (bins_reg == 6'd0) begin
            bins_eff = BCW'(1);
        end else if (int'(bins_reg) > MAX_BINS) begin
            bins_eff = BCW'(MAX_BINS);
        end else begin
            bins_eff = BCW'(bins_reg);
        end
        bins_m1   = BIW'(bins_eff - 1'b1);
        range_eff = (range_reg == 32'd0) ? 32'd1 : range_reg;
        range_s   = $signed({2'b00, range_eff});
    end

    // interpolation and binning operands
    always_comb begin
        obs_cur    = obs_mem[TIW'(next_slot_reg)];
        old_sel    = comp_reg ? pv2_reg : pv1_reg;
        cur_sel    = comp_reg ? v2_reg : v1_reg;
        diff       = 34'(cur_sel) - 34'(old_sel);
        mag        = diff[33] ? 33'(-diff) : 33'(diff);
        q34        = $signed({1'b0, div_quo[32:0]});
        old34      = 34'(old_sel);
        interp_res = neg_reg ? (old34 - q34) : (old34 + q34);
        bv         = comp_reg ? iv2_reg : iv1_reg;
        bs         = bv + range_s;
        if (state_reg == ST_MUL) begin
            mul_a = mag;
            mul_b = num_reg;
        end else begin
            mul_a = bs[32:0];
            mul_b = 32'(bins_m1);
        end
        mul_p = {32'd0, mul_a} * {33'd0, mul_b};
    end

    // histogram addresses
    always_comb begin
        rb2_eff  = two_dim_reg ? rb2_reg : 5'd0;
        rmw_addr = HAW'((int'(next_slot_reg) * MAX_BINS + int'(idx1_reg)) * MAX_BINS
                        + int'(idx2_reg));
        rd_addr  = HAW'((int'(slot_reg) * MAX_BINS + int'(rb1_reg)) * MAX_BINS
                        + int'(rb2_eff));
    end

    // RAM port selection
    always_comb begin
        ram_we    = clr_busy_reg || (state_reg == ST_RMW_WR);
        ram_waddr = clr_busy_reg ? clr_addr_reg : rmw_addr;
        ram_wdata = clr_busy_reg ? 32'd0 :
                    ((ram_rdata == tvh_pkg::COUNT_MAX) ? ram_rdata : ram_rdata + 32'd1);
        ram_re    = (state_reg == ST_RD) || (state_reg == ST_RMW_RD);
        ram_raddr = (state_reg == ST_RD) ? rd_addr : rmw_addr;
    end

    // divider operands
    always_comb begin
        div_ctl.start = (state_reg == ST_DIV_GO) || (state_reg == ST_BDIV_GO);
        if (state_reg == ST_DIV_GO) begin
            div_dividend = prod_reg;
            div_divisor  = {1'b0, den_reg};
        end else begin
            div_dividend = prod_reg + {33'd0, range_eff};
            div_divisor  = {range_eff, 1'b0};
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (act_reg)
                    tvh_pkg::ACT_SAMPLE: state_next = ST_CHECK;
                    tvh_pkg::ACT_READ:   state_next = ST_RD;
                    default:             state_next = ST_FINISH;
                endcase
            end
            ST_CHECK: begin
                if (next_slot_reg < count_w && t_reg > obs_cur) begin
                    state_next = (t_reg <= prev_t_reg) ? ST_BIN : ST_MUL;
                end else begin
                    state_next = ST_END;
                end
            end
            ST_MUL:    state_next = ST_DIV_GO;
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_sts.done) begin
                    state_next = (!comp_reg && two_dim_reg) ? ST_MUL : ST_BIN;
                end
            end
            ST_BIN: begin
                if (bv >= range_s || bv <= -range_s) begin
                    state_next = (!comp_reg && two_dim_reg) ? ST_BIN : ST_RMW_RD;
                end else begin
                    state_next = ST_BDIV_GO;
                end
            end
            ST_BDIV_GO: state_next = ST_BDIV_WAIT;
            ST_BDIV_WAIT: begin
                if (div_sts.done) begin
                    state_next = (!comp_reg && two_dim_reg) ? ST_BIN : ST_RMW_RD;
                end
            end
            ST_RMW_RD:  state_next = ST_RMW_WR;
            ST_RMW_WR:  state_next = ST_CHECK;
            ST_END:     state_next = ST_FINISH;
            ST_RD:      state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = ST_FINISH;
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // advance the slot after each recorded histogram
    always_comb begin
        next_slot_next = next_slot_reg;
        if (state_reg == ST_EXEC && act_reg == tvh_pkg::ACT_START) begin
            next_slot_next = '0;
        end else if (state_reg == ST_RMW_WR) begin
            next_slot_next = next_slot_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            two_dim_reg   <= 1'b0;
            bins_reg      <= 6'd32;
            range_reg     <= 32'd98304;
            tcount_reg    <= 5'd0;
            next_slot_reg <= '0;
            prev_t_reg    <= 32'd0;
            pv1_reg       <= 32'sd0;
            pv2_reg       <= 32'sd0;
            m_valid_reg   <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            next_slot_reg <= next_slot_next;

            // take configuration writes
            if (cfg_we) begin
                case (cfg_index)
                    tvh_pkg::REG_TWO_DIM: two_dim_reg <= cfg_data[0];
                    tvh_pkg::REG_BINS:    bins_reg    <= cfg_data[5:0];
                    tvh_pkg::REG_RANGE:   range_reg   <= cfg_data;
                    tvh_pkg::REG_TCOUNT:  tcount_reg  <= cfg_data[4:0];
                    default: ;
                endcase
            end

            // sweep the histogram RAM to zero
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == HAW'(HIST_SIZE - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end

            // start of trajectory
            if (state_reg == ST_EXEC && act_reg == tvh_pkg::ACT_START) begin
                prev_t_reg <= 32'd0;
                pv1_reg    <= v1_reg;
                pv2_reg    <= v2_reg;
            end

            // keep the sample as the previous point while times remain
            if (state_reg == ST_END && next_slot_reg < count_w) begin
                prev_t_reg <= t_reg;
                pv1_reg    <= v1_reg;
                pv2_reg    <= v2_reg;
            end

            // hand the result to the output register
            if (state_reg == ST_FINISH && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg  <= s_action;
            t_reg    <= s_time_value;
            v1_reg   <= s_vel_first;
            v2_reg   <= s_vel_second;
            slot_reg <= s_slot_index;
            rb1_reg  <= s_read_bin_first;
            rb2_reg  <= s_read_bin_second;
        end

        case (state_reg)
            ST_EXEC: begin
                rec_reg      <= '0;
                res_keep_reg <= 1'b0;
                res_val_reg  <= 32'd0;
                rd_ok_reg    <= (int'(slot_reg) < MAX_TIMES) && (int'(rb1_reg) < MAX_BINS)
                                && (int'(rb2_eff) < MAX_BINS);
                if (act_reg == tvh_pkg::ACT_LOAD && int'(slot_reg) < MAX_TIMES) begin
                    obs_mem[TIW'(slot_reg)] <= t_reg;
                end
            end
            ST_CHECK: begin
                comp_reg <= 1'b0;
                idx2_reg <= '0;
                iv1_reg  <= 34'(v1_reg);
                iv2_reg  <= 34'(v2_reg);
                num_reg  <= (obs_cur > prev_t_reg) ? obs_cur - prev_t_reg : 32'd0;
                den_reg  <= t_reg - prev_t_reg;
            end
            ST_MUL: begin
                prod_reg <= mul_p;
                neg_reg  <= diff[33];
            end
            ST_DIV_WAIT: begin
                if (div_sts.done) begin
                    if (comp_reg) begin
                        iv2_reg <= interp_res;
                    end else begin
                        iv1_reg <= interp_res;
                    end
                    comp_reg <= !comp_reg && two_dim_reg;
                end
            end
            ST_BIN: begin
                prod_reg <= mul_p;
                if (bv >= range_s || bv <= -range_s) begin
                    if (comp_reg) begin
                        idx2_reg <= (bv >= range_s) ? bins_m1 : '0;
                    end else begin
                        idx1_reg <= (bv >= range_s) ? bins_m1 : '0;
                    end
                    comp_reg <= !comp_reg && two_dim_reg;
                end
            end
            ST_BDIV_WAIT: begin
                if (div_sts.done) begin
                    if (comp_reg) begin
                        idx2_reg <= div_quo[BIW-1:0];
                    end else begin
                        idx1_reg <= div_quo[BIW-1:0];
                    end
                    comp_reg <= !comp_reg && two_dim_reg;
                end
            end
            ST_RMW_WR: begin
                rec_reg <= rec_reg + 1'b1;
            end
            ST_END: begin
                res_keep_reg <= next_slot_reg < count_w;
            end
            ST_RD_DATA: begin
                res_val_reg <= rd_ok_reg ? ram_rdata : 32'd0;
            end
            default: ;
        endcase

        if (state_reg == ST_FINISH && (!m_valid_reg || m_ready)) begin
            m_keep_reg <= res_keep_reg;
            m_rec_reg  <= 5'(rec_reg);
            m_val_reg  <= res_val_reg;
        end
    end

    tvh_ram #(
        .WIDTH (32),
        .DEPTH (HIST_SIZE)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tvh_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    assign s_ready          = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign m_valid          = m_valid_reg;
    assign m_keep_tracing   = m_keep_reg;
    assign m_recorded_count = m_rec_reg;
    assign m_bin_value      = m_val_reg;

    // no item while the clearing pass runs
    a_ready_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !clr_busy_reg)
        else $error("item taken during histogram clear");

    // a bin write always follows its read
    a_rmw_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RMW_WR) |-> ($past(state_reg) == ST_RMW_RD))
        else $error("histogram write without read");

    // a result is either a sample answer or a read answer
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_rec_reg != 5'd0 || m_keep_reg)) |-> (m_val_reg == 32'd0))
        else $error("mixed result fields");

    // slot pointer stays in range
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(next_slot_reg) <= MAX_TIMES)
        else $error("slot pointer overrun");

endmodule

[test/tb_timed_velocity_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_velocity_histogram: self-checking bench for the velocity histogram
// Loads observation times and runs trajectories of samples through several
// register settings. A local predictor keeps its own histogram and trajectory
// state, and every result item is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_timed_velocity_histogram;

    localparam int NTIMES = 16;
    localparam int NBINS  = 32;
    localparam int HSIZE  = NTIMES * NBINS * NBINS;
    localparam int ONE    = 65536;

    typedef struct {
        logic [1:0]         action;
        logic [31:0]        tval;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic [3:0]         slot;
        logic [4:0]         rb1;
        logic [4:0]         rb2;
    } item_t;

    typedef struct {
        logic        keep;
        logic [4:0]  rec;
        logic [31:0] val;
    } result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action = '0;
    logic [31:0]        s_time_value = '0;
    logic signed [31:0] s_vel_first = '0;
    logic signed [31:0] s_vel_second = '0;
    logic [3:0]         s_slot_index = '0;
    logic [4:0]         s_read_bin_first = '0;
    logic [4:0]         s_read_bin_second = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_keep_tracing;
    logic [4:0]         m_recorded_count;
    logic [31:0]        m_bin_value;

    timed_velocity_histogram uut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // predictor state
    logic        mdl_two_dim;
    logic [5:0]  mdl_bins;
    logic [31:0] mdl_range;
    logic [4:0]  mdl_tcount;
    logic [31:0] mdl_obs [NTIMES];
    logic [31:0] mdl_hist [HSIZE];
    int unsigned mdl_next;
    logic [31:0] mdl_prev_t;
    longint      mdl_prev_v1;
    longint      mdl_prev_v2;

    item_t   pending [$];
    result_t expected [$];
    item_t   cur;
    int      gap = 0;
    int      rwait = 0;
    int      long_hold = 0;
    int      hold_req = 0;
    int      hold_ack = 0;
    int      n_accepted = 0;
    int      n_results = 0;
    int      n_errors = 0;
    int      n_phases = 0;

    function automatic longint lerp_vel(longint old, longint cv, longint unsigned num,
                                        longint unsigned den);
        longint diff;
        longint unsigned mag, q;
        diff = cv - old;
        mag = diff < 0 ? longint'(-diff) : diff;
        q = mag * num / den;
        return diff < 0 ? old - longint'(q) : old + longint'(q);
    endfunction

    function automatic int unsigned vel_bin(longint v, longint unsigned rng,
                                            longint unsigned nb);
        longint unsigned s;
        if (v >= longint'(rng)) return 32'(nb - 1);
        if (v <= -longint'(rng)) return 0;
        s = v + longint'(rng);
        return 32'((s * (nb - 1) + rng) / (2 * rng));
    endfunction

    task automatic count_bin(int unsigned slot, longint a, longint b);
        longint unsigned rng, nb;
        int unsigned i1, i2, addr;
        rng = mdl_range == 0 ? 1 : mdl_range;
        nb = mdl_bins < 1 ? 1 : (mdl_bins > NBINS ? NBINS : mdl_bins);
        i1 = vel_bin(a, rng, nb);
        i2 = mdl_two_dim ? vel_bin(b, rng, nb) : 0;
        addr = (slot * NBINS + i1) * NBINS + i2;
        if (addr < HSIZE && mdl_hist[addr] != tvh_pkg::COUNT_MAX) mdl_hist[addr]++;
    endtask

    // compute the result of one accepted item and advance the model
    task automatic predict_histogram(item_t it, output result_t r);
        int unsigned cnt;
        longint a, b;
        longint unsigned den, num;
        logic [4:0] rb2;
        r = '{1'b0, 5'd0, 32'd0};
        cnt = mdl_tcount < NTIMES ? mdl_tcount : NTIMES;
        case (it.action)
            tvh_pkg::ACT_START: begin
                mdl_prev_v1 = it.v1;
                mdl_prev_v2 = it.v2;
                mdl_prev_t = 0;
                mdl_next = 0;
            end
            tvh_pkg::ACT_SAMPLE: begin
                if (mdl_next < cnt) begin
                    while (mdl_next < cnt && it.tval > mdl_obs[mdl_next]) begin
                        if (it.tval <= mdl_prev_t) begin
                            a = it.v1;
                            b = it.v2;
                        end else begin
                            den = it.tval - mdl_prev_t;
                            num = mdl_obs[mdl_next] > mdl_prev_t ?
                                  mdl_obs[mdl_next] - mdl_prev_t : 0;
                            a = lerp_vel(mdl_prev_v1, it.v1, num, den);
                            b = lerp_vel(mdl_prev_v2, it.v2, num, den);
                        end
                        count_bin(mdl_next, a, b);
                        r.rec++;
                        mdl_next++;
                    end
                    if (mdl_next < cnt) begin
                        r.keep = 1'b1;
                        mdl_prev_v1 = it.v1;
                        mdl_prev_v2 = it.v2;
                        mdl_prev_t = it.tval;
                    end
                end
            end
            tvh_pkg::ACT_LOAD: mdl_obs[it.slot] = it.tval;
            default: begin
                rb2 = mdl_two_dim ? it.rb2 : 5'd0;
                r.val = mdl_hist[(it.slot * NBINS + it.rb1) * NBINS + rb2];
            end
        endcase
    endtask

    // append one item to the driver's queue
    task automatic queue_item(item_t it);
        pending = {pending, it};
    endtask

    // driver: offer queued items with random gaps, bursts every third block
    always @(posedge aclk) begin
        result_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_histogram(cur, r);
                expected = {expected, r};
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    cur = pending.pop_front();
                    s_action <= cur.action;
                    s_time_value <= cur.tval;
                    s_vel_first <= cur.v1;
                    s_vel_second <= cur.v2;
                    s_slot_index <= cur.slot;
                    s_read_bin_first <= cur.rb1;
                    s_read_bin_second <= cur.rb2;
                    s_valid <= 1'b1;
                    gap <= ((n_accepted / 40) % 3 == 0) ? 0 : $urandom_range(0, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold, counted on its own
    always @(posedge aclk) begin
        if (!aresetn) begin
            long_hold <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            long_hold <= 400;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
        end
    end

    // monitor: check results, stall at random and during the long hold
    always @(posedge aclk) begin
        result_t e;
        int w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result item at %0t", $time);
                end else begin
                    e = expected.pop_front();
                    if (e.keep !== m_keep_tracing || e.rec !== m_recorded_count ||
                        e.val !== m_bin_value) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch %0t: exp keep=%0d rec=%0d val=%h, got %0d %0d %h",
                                     $time, e.keep, e.rec, e.val, m_keep_tracing,
                                     m_recorded_count, m_bin_value);
                    end
                end
            end
            if (hold_req != hold_ack || long_hold > 0) begin
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                w = ((n_results / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
                rwait <= w > 0 ? w - 1 : 0;
                m_ready <= (w == 0);
            end else if (rwait > 0) begin
                rwait <= rwait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic item_t mk(logic [1:0] act, logic [31:0] t, logic [31:0] a,
                                 logic [31:0] b, logic [31:0] sl, logic [31:0] r1,
                                 logic [31:0] r2);
        item_t it;
        it.action = act;
        it.tval = t;
        it.v1 = a;
        it.v2 = b;
        it.slot = sl[3:0];
        it.rb1 = r1[4:0];
        it.rb2 = r2[4:0];
        return it;
    endfunction

    function automatic logic [31:0] rnd_vel();
        longint lim;
        if ($urandom_range(0, 3) == 0) return $urandom;
        lim = (longint'(mdl_range == 0 ? 1 : mdl_range) * 3) / 2;
        if (lim > 32'h7FFF_FFFF) lim = 32'h7FFF_FFFF;
        return 32'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
    endfunction

    function automatic item_t rnd_read();
        int nb;
        nb = mdl_bins < 1 ? 1 : (mdl_bins > NBINS ? NBINS : mdl_bins);
        if ($urandom_range(0, 1))
            return mk(tvh_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, nb - 1), $urandom_range(0, nb - 1));
        return mk(tvh_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
    endfunction

    task automatic wait_idle();
        while (pending.size() > 0 || s_valid || expected.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        case (idx)
            tvh_pkg::REG_TWO_DIM: mdl_two_dim = d[0];
            tvh_pkg::REG_BINS:    mdl_bins = d[5:0];
            tvh_pkg::REG_RANGE:   mdl_range = d;
            tvh_pkg::REG_TCOUNT:  mdl_tcount = d[4:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic two, logic [5:0] nb, logic [31:0] rng, logic [4:0] tc);
        wait_idle();
        write_reg(tvh_pkg::REG_TWO_DIM, 32'(two));
        write_reg(tvh_pkg::REG_BINS, 32'(nb));
        write_reg(tvh_pkg::REG_RANGE, rng);
        write_reg(tvh_pkg::REG_TCOUNT, 32'(tc));
        n_phases++;
    endtask

    // load all slots, increasing unless scrambled
    task automatic load_times(bit scrambled);
        longint t;
        t = $urandom_range(0, ONE);
        for (int k = 0; k < NTIMES; k++) begin
            queue_item(mk(tvh_pkg::ACT_LOAD,
                          scrambled ? $urandom_range(0, 40 * ONE) : 32'(t),
                          $urandom, $urandom, k, $urandom, $urandom));
            t += $urandom_range(1, 4 * ONE);
        end
    endtask

    // one trajectory: a start and rising sample times, some noise mixed in
    task automatic run_trajectory(inout int budget);
        longint t;
        int ns;
        t = 0;
        queue_item(mk(tvh_pkg::ACT_START, $urandom, rnd_vel(), rnd_vel(), $urandom,
                      $urandom, $urandom));
        budget--;
        ns = $urandom_range(4, 16);
        for (int k = 0; k < ns && budget > 0; k++) begin
            case ($urandom_range(0, 9))
                0: queue_item(mk(tvh_pkg::ACT_SAMPLE, $urandom_range(0, 32'(t)), rnd_vel(),
                                 rnd_vel(), $urandom, $urandom, $urandom));
                1, 2: queue_item(rnd_read());
                default: begin
                    t += $urandom_range(1, 6 * ONE);
                    if (t > 32'hFFFF_FFFF) t = 32'hFFFF_FFFF;
                    queue_item(mk(tvh_pkg::ACT_SAMPLE, 32'(t), rnd_vel(), rnd_vel(),
                                  $urandom, $urandom, $urandom));
                end
            endcase
            budget--;
        end
    endtask

    task automatic run_phase(logic two, logic [5:0] nb, logic [31:0] rng, logic [4:0] tc,
                             bit scrambled, int budget);
        set_regs(two, nb, rng, tc);
        load_times(scrambled);
        budget -= NTIMES;
        while (budget > 0) run_trajectory(budget);
    endtask

    initial begin
        mdl_two_dim = 1'b0;
        mdl_bins = 6'd32;
        mdl_range = 32'd98304;
        mdl_tcount = 5'd0;
        foreach (mdl_obs[k]) mdl_obs[k] = '0;
        foreach (mdl_hist[k]) mdl_hist[k] = '0;
        mdl_next = 0;
        mdl_prev_t = 0;
        mdl_prev_v1 = 0;
        mdl_prev_v2 = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset registers, no times in use, so samples finish at once
        load_times(1'b0);
        queue_item(mk(tvh_pkg::ACT_START, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        queue_item(mk(tvh_pkg::ACT_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        queue_item(mk(tvh_pkg::ACT_READ, 0, 0, 0, 15, 31, 31));

        // directed: all times in use, extreme velocities and times
        set_regs(1'b1, 6'd32, 32'd98304, 5'd16);
        queue_item(mk(tvh_pkg::ACT_START, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
        queue_item(mk(tvh_pkg::ACT_SAMPLE, mdl_obs[0] + 1, 32'h7FFF_FFFF, 32'h8000_0000,
                      0, 0, 0));
        // non-increasing time takes the current velocity
        queue_item(mk(tvh_pkg::ACT_SAMPLE, 1, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0));
        queue_item(mk(tvh_pkg::ACT_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        queue_item(mk(tvh_pkg::ACT_SAMPLE, 32'hFFFF_FFFF, 1, 1, 0, 0, 0));
        queue_item(mk(tvh_pkg::ACT_READ, 0, 0, 0, 0, 0, 31));
        queue_item(mk(tvh_pkg::ACT_READ, 0, 0, 0, 0, 31, 0));
        queue_item(mk(tvh_pkg::ACT_READ, 0, 0, 0, 15, 16, 16));

        // random phases over several settings, extremes included
        run_phase(1'b0, 6'd32, 32'd98304, 5'd16, 1'b0, 110);
        hold_req++;
        run_phase(1'b1, 6'd1, 32'd1, 5'd5, 1'b0, 100);
        run_phase(1'b1, 6'd32, 32'hFFFF_FFFF, 5'd16, 1'b0, 110);
        // sender pauses between phases until every result is back
        wait_idle();
        run_phase(1'b0, 6'd7, 32'd65536, 5'd16, 1'b1, 100);
        run_phase(1'b1, 6'($urandom_range(2, 31)), $urandom_range(ONE / 4, 8 * ONE),
                  5'($urandom_range(1, 16)), 1'b0, 110);
        run_phase(1'b0, 6'd63, 32'd3 * ONE, 5'd0, 1'b0, 60);
        run_phase(1'b1, 6'd0, 32'd0, 5'd16, 1'b0, 110);
        hold_req++;
        run_phase(1'b0, 6'($urandom_range(1, 32)), $urandom, 5'd16, 1'b0, 110);
        run_phase(1'b1, 6'd13, 32'd98304, 5'd12, 1'b1, 90);

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("covered %0d register settings, %0d items in, %0d results checked",
                 n_phases, n_accepted, n_results);
        if (n_errors == 0 && expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", expected.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
